@@ rtl/core/vcrw_pkg.sv @@
// Package for the video controller register-write decoder.
// Holds the register and sub-register codes and the pixel depth lookup.
// No dependencies.
package vcrw_pkg;

  // Register select codes, bits 31:28 of the written word.
  localparam logic [3:0] REG_PALETTE_DATA  = 4'h0;
  localparam logic [3:0] REG_PALETTE_INDEX = 4'h1;
  localparam logic [3:0] REG_HORIZONTAL    = 4'h8;
  localparam logic [3:0] REG_VERTICAL      = 4'h9;
  localparam logic [3:0] REG_CONTROL       = 4'he;
  localparam logic [3:0] REG_DATA_CONTROL  = 4'hf;

  // Sub-register select codes, bits 27:24, inside the horizontal and vertical groups.
  localparam logic [3:0] SUB_DISPLAY_START = 4'h3;
  localparam logic [3:0] SUB_DISPLAY_END   = 4'h4;
  localparam logic [3:0] SUB_CURSOR_START  = 4'h6;
  localparam logic [3:0] SUB_CURSOR_END    = 4'h7;

  // Field widths of the stored geometry.
  localparam int HPOS_W   = 14;
  localparam int VPOS_W   = 13;
  localparam int DEPTH_W  = 6;

  // Pixel depth in bits for each control code; reserved codes give zero.
  function automatic logic [DEPTH_W-1:0] depth_lookup(input logic [2:0] code);
    logic [DEPTH_W-1:0] depth;
    case (code)
      3'd0: depth = 6'd1;
      3'd1: depth = 6'd2;
      3'd2: depth = 6'd4;
      3'd3: depth = 6'd8;
      3'd4: depth = 6'd16;
      3'd6: depth = 6'd32;
      default: depth = 6'd0;
    endcase
    return depth;
  endfunction

endpackage

@@ rtl/core/video_controller_register_writes.sv @@
// Top level of the video controller register-write decoder.
// Uses vcrw_pkg for register codes and the pixel depth lookup.
//
// Usage:
//   The input channel (in_valid, in_stall, bus_data) takes one 32-bit bus
//   write per item. Bits 31:28 select the register and bits 27:24 the
//   sub-register. Each input item produces exactly one result item on the
//   output channel (out_valid, out_stall and the result fields), which
//   reports any palette colour stored and the display geometry after the
//   write has been applied.
//   The state update and the result are computed from the incoming word
//   and the current state and land in the result register at the
//   accepting edge. Throughput is one item per cycle while out_stall is low;
//   the decode, the small subtractions and the depth lookup set the path.
//   When the receiver stalls, the result register holds its item and
//   in_stall rises only while that held result cannot be taken, so a new
//   item is accepted in the same cycle that the old result leaves.
//   Reset (rst, synchronous, active high) clears the palette pointer, the
//   display-active flag, all geometry registers and the output valid flag.
module video_controller_register_writes (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        bus_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               palette_write,
  output logic [7:0]         palette_index,
  output logic [7:0]         palette_red,
  output logic [7:0]         palette_green,
  output logic [7:0]         palette_blue,
  output logic               mode_set,
  output logic signed [14:0] width,
  output logic signed [13:0] height,
  output logic [5:0]         bits_per_pixel,
  output logic signed [14:0] cursor_x,
  output logic signed [15:0] cursor_y,
  output logic signed [16:0] cursor_height
);

  // Stored controller state.
  logic [7:0]                       palette_pointer;
  logic                             display_active;
  logic [vcrw_pkg::HPOS_W-1:0]      h_display_start;
  logic [vcrw_pkg::HPOS_W-1:0]      h_display_end;
  logic [vcrw_pkg::VPOS_W-1:0]      v_display_start;
  logic [vcrw_pkg::VPOS_W-1:0]      v_display_end;
  logic [14:0]                      cursor_left;
  logic [16:0]                      cursor_top;
  logic [16:0]                      cursor_bottom;
  logic [vcrw_pkg::DEPTH_W-1:0]     pixel_depth;

  logic [7:0]                       palette_pointer_next;
  logic                             display_active_next;
  logic [vcrw_pkg::HPOS_W-1:0]      h_display_start_next;
  logic [vcrw_pkg::HPOS_W-1:0]      h_display_end_next;
  logic [vcrw_pkg::VPOS_W-1:0]      v_display_start_next;
  logic [vcrw_pkg::VPOS_W-1:0]      v_display_end_next;
  logic [14:0]                      cursor_left_next;
  logic [16:0]                      cursor_top_next;
  logic [16:0]                      cursor_bottom_next;
  logic [vcrw_pkg::DEPTH_W-1:0]     pixel_depth_next;

  logic                             palette_write_next;
  logic                             mode_set_next;
  logic [14:0]                      width_now;
  logic [13:0]                      height_now;

  logic [3:0]                       reg_sel;
  logic [3:0]                       sub_sel;
  logic                             accept;

  // Handshake: stall only while a finished result is held by the receiver.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign reg_sel = bus_data[31:28];
  assign sub_sel = bus_data[27:24];

  // Current display size; a data-control write leaves the geometry unchanged.
  assign width_now  = {1'b0, h_display_end} - {1'b0, h_display_start};
  assign height_now = {1'b0, v_display_end} - {1'b0, v_display_start};

  // Register decode and next state.
  always_comb begin
    palette_pointer_next = palette_pointer;
    display_active_next  = display_active;
    h_display_start_next = h_display_start;
    h_display_end_next   = h_display_end;
    v_display_start_next = v_display_start;
    v_display_end_next   = v_display_end;
    cursor_left_next     = cursor_left;
    cursor_top_next      = cursor_top;
    cursor_bottom_next   = cursor_bottom;
    pixel_depth_next     = pixel_depth;
    palette_write_next   = 1'b0;
    mode_set_next        = 1'b0;
    case (reg_sel)
      vcrw_pkg::REG_PALETTE_DATA: begin
        if (display_active) begin
          palette_write_next   = 1'b1;
          palette_pointer_next = palette_pointer + 8'd1;
        end
      end
      vcrw_pkg::REG_PALETTE_INDEX: begin
        palette_pointer_next = bus_data[7:0];
      end
      vcrw_pkg::REG_HORIZONTAL: begin
        case (sub_sel)
          vcrw_pkg::SUB_DISPLAY_START: h_display_start_next = bus_data[13:0];
          vcrw_pkg::SUB_DISPLAY_END:   h_display_end_next   = bus_data[13:0];
          vcrw_pkg::SUB_CURSOR_START:
            cursor_left_next = {1'b0, bus_data[13:0]} - {1'b0, h_display_start};
          default: ;
        endcase
      end
      vcrw_pkg::REG_VERTICAL: begin
        case (sub_sel)
          vcrw_pkg::SUB_DISPLAY_START: v_display_start_next = bus_data[12:0];
          vcrw_pkg::SUB_DISPLAY_END:   v_display_end_next   = bus_data[12:0];
          vcrw_pkg::SUB_CURSOR_START:
            cursor_top_next = {2'b0, bus_data[14:0]} - {4'b0, v_display_start};
          vcrw_pkg::SUB_CURSOR_END:
            cursor_bottom_next = {2'b0, bus_data[14:0]} - {4'b0, v_display_start};
          default: ;
        endcase
      end
      vcrw_pkg::REG_CONTROL: begin
        pixel_depth_next = vcrw_pkg::depth_lookup(bus_data[10:8]);
      end
      vcrw_pkg::REG_DATA_CONTROL: begin
        if ((width_now != 15'd0) && (height_now != 14'd0)) begin
          display_active_next = 1'b1;
          mode_set_next       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_pointer <= '0;
      display_active  <= 1'b0;
      h_display_start <= '0;
      h_display_end   <= '0;
      v_display_start <= '0;
      v_display_end   <= '0;
      cursor_left     <= '0;
      cursor_top      <= '0;
      cursor_bottom   <= '0;
      pixel_depth     <= '0;
    end else if (accept) begin
      palette_pointer <= palette_pointer_next;
      display_active  <= display_active_next;
      h_display_start <= h_display_start_next;
      h_display_end   <= h_display_end_next;
      v_display_start <= v_display_start_next;
      v_display_end   <= v_display_end_next;
      cursor_left     <= cursor_left_next;
      cursor_top      <= cursor_top_next;
      cursor_bottom   <= cursor_bottom_next;
      pixel_depth     <= pixel_depth_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register; geometry reflects the state after this write.
  always_ff @(posedge clk) begin
    if (accept) begin
      palette_write  <= palette_write_next;
      palette_index  <= palette_write_next ? palette_pointer : 8'd0;
      palette_red    <= palette_write_next ? bus_data[7:0] : 8'd0;
      palette_green  <= palette_write_next ? bus_data[15:8] : 8'd0;
      palette_blue   <= palette_write_next ? bus_data[23:16] : 8'd0;
      mode_set       <= mode_set_next;
      width          <= $signed({1'b0, h_display_end_next} - {1'b0, h_display_start_next});
      height         <= $signed({1'b0, v_display_end_next} - {1'b0, v_display_start_next});
      bits_per_pixel <= pixel_depth_next;
      cursor_x       <= $signed(cursor_left_next);
      cursor_y       <= $signed(cursor_top_next[15:0]);
      cursor_height  <= $signed(cursor_bottom_next - cursor_top_next);
    end
  end

endmodule

@@ rtl/core/vcrw_checker.sv @@
// Port-level checker for the video controller register-write decoder.
// Bound to video_controller_register_writes; uses no package.
module vcrw_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               palette_write,
  input logic [7:0]         palette_index,
  input logic [7:0]         palette_red,
  input logic [7:0]         palette_green,
  input logic [7:0]         palette_blue,
  input logic               mode_set,
  input logic signed [14:0] width,
  input logic signed [13:0] height
);

  // Every accepted item shows up as a result in the following cycle.
  a_one_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item did not produce a result");

  // A result that leaves with no new item behind it clears the output.
  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !(in_valid && !in_stall)) |=> !out_valid)
    else $error("result repeated or invented");

  // A held result stays valid.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result was dropped");

  // Palette fields read zero when no colour was stored.
  a_palette_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !palette_write) |->
      (palette_index == 8'd0 && palette_red == 8'd0 &&
       palette_green == 8'd0 && palette_blue == 8'd0))
    else $error("palette fields not cleared without a palette write");

  // A mode is only activated with a nonzero display size.
  a_mode_needs_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode_set) |-> (width != 15'sd0 && height != 14'sd0))
    else $error("mode set with a zero display size");

endmodule

bind video_controller_register_writes vcrw_checker u_vcrw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .palette_write (palette_write),
  .palette_index (palette_index),
  .palette_red   (palette_red),
  .palette_green (palette_green),
  .palette_blue  (palette_blue),
  .mode_set      (mode_set),
  .width         (width),
  .height        (height)
);
